// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with a given synchronous reset.
`define DRBD_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define DRBD_ASSERT(lbl, prop, msg) `DRBD_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ----- hdl/drbd_pkg.sv -----
// Types and constants shared by the decompressor modules.
package drbd_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
   localparam int PAIR_W        = 16;
   localparam int BANK_SHIFT    = 18;
   localparam int OFFSET_W      = 21;
   localparam int COUNT_W       = 9;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_STREAM = 2'd2;

   localparam logic CSR_DEST_BANK = 1'b0;
   localparam logic CSR_LENGTH    = 1'b1;

   localparam logic [8:0] SENT_A = 9'h1FE;
   localparam logic [8:0] SENT_B = 9'h1FF;

   localparam logic [3:0] GROUP_TOKENS = 4'd8;
   localparam logic [1:0] QUEUE_DEPTH  = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] table_index;
      logic [7:0] pair_first;
      logic [7:0] pair_second;
      logic [7:0] stream_byte;
   } req_item_type;

   typedef struct packed {
      logic [23:0]        dest_address;
      logic [7:0]         fill_value;
      logic [COUNT_W-1:0] fill_count;
      logic               job_done;
   } rsp_item_type;

   typedef struct packed {
      logic       is_start;
      logic [7:0] stream_byte;
      logic [7:0] pair_first;
      logic [7:0] pair_second;
   } mid_item_type;

   typedef struct packed {
      logic [1:0] count;
   } queue_stat_type;

   typedef struct packed {
      logic phase;
      logic job_active;
   } back_stat_type;

endpackage

// ----- hdl/drbd_ram.sv -----
// Generic single write port RAM with a registered read port.
module drbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/drbd_front.sv -----
// Front end: accepts items, keeps the pair table and forwards start and stream items.
module drbd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  drbd_pkg::req_item_type req_item,
   output logic                   req_full,
   input  drbd_pkg::queue_stat_type mid_stat,
   output logic                   mid_push,
   output drbd_pkg::mid_item_type mid_item
);

   logic                             accept;
   logic                             keep;
   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic                             s1_start_ff;
   logic [7:0]                       s1_byte_ff;
   logic [drbd_pkg::PAIR_W-1:0]      pair_rd;

   assign req_full = s1_valid_ff && (mid_stat.count == drbd_pkg::QUEUE_DEPTH);
   assign accept   = req_push && !req_full;
   assign mid_push = s1_valid_ff && (mid_stat.count != drbd_pkg::QUEUE_DEPTH);
   assign keep     = accept && ((req_item.action == drbd_pkg::ACT_START) ||
                                (req_item.action == drbd_pkg::ACT_STREAM));

   always_comb begin
      if (keep) begin
         s1_valid_in = 1'b1;
      end else if (mid_push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         s1_start_ff <= (req_item.action == drbd_pkg::ACT_START);
         s1_byte_ff  <= req_item.stream_byte;
      end
   end

   drbd_ram #(
      .WIDTH(drbd_pkg::PAIR_W),
      .DEPTH(drbd_pkg::TABLE_ENTRIES)
   ) u_pair_table (
      .clock   (clock),
      .wr_en   (accept && (req_item.action == drbd_pkg::ACT_LOAD)),
      .wr_addr (req_item.table_index),
      .wr_data ({req_item.pair_second, req_item.pair_first}),
      .rd_en   (accept && (req_item.action == drbd_pkg::ACT_STREAM)),
      .rd_addr (req_item.stream_byte),
      .rd_data (pair_rd)
   );

   always_comb begin
      mid_item.is_start    = s1_start_ff;
      mid_item.stream_byte = s1_byte_ff;
      mid_item.pair_first  = pair_rd[7:0];
      mid_item.pair_second = pair_rd[15:8];
   end

endmodule

// ----- hdl/drbd_queue.sv -----
// Two-entry queue between the front end and the decoder.
module drbd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  drbd_pkg::mid_item_type   push_item,
   input  logic                     pop,
   output drbd_pkg::mid_item_type   head_item,
   output drbd_pkg::queue_stat_type stat
);

   drbd_pkg::mid_item_type mem_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;

endmodule

// ----- hdl/drbd_back.sv -----
// Decoder back end: group sequencing, run-length stage and result queue.
module drbd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  drbd_pkg::mid_item_type   head_item,
   input  drbd_pkg::queue_stat_type mid_stat,
   output logic                     mid_pop,
   input  logic [5:0]               dest_bank,
   input  logic [17:0]              length_field,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output drbd_pkg::rsp_item_type   rsp_item,
   output drbd_pkg::back_stat_type  stat
);

   logic [8:0]                    last_ff,  last_in;
   logic [8:0]                    prev_ff,  prev_in;
   logic [drbd_pkg::OFFSET_W-1:0] off_ff,   off_in;
   logic [7:0]                    flags_ff, flags_in;
   logic [3:0]                    gpos_ff,  gpos_in;
   logic                          active_ff, active_in;
   logic                          phase_ff, phase_in;

   logic                          have;
   logic                          out_space;
   logic                          step;
   logic                          dict;
   logic                          last_step;
   logic [7:0]                    sel_byte;
   logic                          run;
   logic [drbd_pkg::COUNT_W-1:0]  count;
   logic [7:0]                    value;
   logic [drbd_pkg::OFFSET_W-1:0] new_off;
   logic [18:0]                   len_plus;
   logic [drbd_pkg::OFFSET_W-1:0] limit;
   logic                          done;
   drbd_pkg::rsp_item_type        rsp_new;

   drbd_pkg::rsp_item_type        out_mem_ff [2];
   logic                          out_wr_ptr_ff;
   logic                          out_rd_ptr_ff;
   logic [1:0]                    out_count_ff, out_count_in;
   logic                          out_pop;

   assign have      = (mid_stat.count != 2'd0);
   assign out_space = (out_count_ff != drbd_pkg::QUEUE_DEPTH);
   assign dict      = flags_ff[7];
   assign last_step = !dict || phase_ff;
   assign step      = have && !head_item.is_start && active_ff &&
                      (gpos_ff != 4'd0) && out_space;

   always_comb begin
      if (!dict) begin
         sel_byte = head_item.stream_byte;
      end else if (phase_ff) begin
         sel_byte = head_item.pair_second;
      end else begin
         sel_byte = head_item.pair_first;
      end
   end

   assign run      = (last_ff == prev_ff);
   assign count    = run ? {1'b0, sel_byte + 8'd1} : 9'd1;
   assign value    = run ? last_ff[7:0] : sel_byte;
   assign new_off  = off_ff + {{(drbd_pkg::OFFSET_W - drbd_pkg::COUNT_W){1'b0}}, count};
   assign len_plus = {1'b0, length_field} + 19'd1;
   assign limit    = {len_plus, 2'b00};
   assign done     = last_step && (new_off >= limit);

   always_comb begin
      rsp_new.dest_address = {dest_bank, {drbd_pkg::BANK_SHIFT{1'b0}}} +
                             {3'b000, off_ff};
      rsp_new.fill_value   = value;
      rsp_new.fill_count   = count;
      rsp_new.job_done     = done;
   end

   assign mid_pop = have && (head_item.is_start || !active_ff || (gpos_ff == 4'd0) ||
                             (step && last_step));

   always_comb begin
      last_in   = last_ff;
      prev_in   = prev_ff;
      off_in    = off_ff;
      flags_in  = flags_ff;
      gpos_in   = gpos_ff;
      active_in = active_ff;
      phase_in  = phase_ff;
      if (have && head_item.is_start) begin
         last_in   = drbd_pkg::SENT_A;
         prev_in   = drbd_pkg::SENT_B;
         off_in    = '0;
         flags_in  = 8'd0;
         gpos_in   = 4'd0;
         active_in = 1'b1;
         phase_in  = 1'b0;
      end else if (have && active_ff && (gpos_ff == 4'd0)) begin
         flags_in = head_item.stream_byte;
         gpos_in  = 4'd1;
      end else if (step) begin
         off_in  = new_off;
         prev_in = run ? drbd_pkg::SENT_B : last_ff;
         last_in = run ? last_ff : {1'b0, sel_byte};
         if (last_step) begin
            flags_in = {flags_ff[6:0], 1'b0};
            gpos_in  = (gpos_ff == drbd_pkg::GROUP_TOKENS) ? 4'd0 : gpos_ff + 4'd1;
            phase_in = 1'b0;
            if (done) begin
               active_in = 1'b0;
            end
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= drbd_pkg::SENT_A;
         prev_ff   <= drbd_pkg::SENT_B;
         off_ff    <= '0;
         flags_ff  <= 8'd0;
         gpos_ff   <= 4'd0;
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         last_ff   <= last_in;
         prev_ff   <= prev_in;
         off_ff    <= off_in;
         flags_ff  <= flags_in;
         gpos_ff   <= gpos_in;
         active_ff <= active_in;
         phase_ff  <= phase_in;
      end
   end

   assign rsp_empty = (out_count_ff == 2'd0);
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      out_count_in = out_count_ff;
      if (step && !out_pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (out_pop && !step) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
         out_count_ff  <= 2'd0;
      end else begin
         if (step) begin
            out_wr_ptr_ff <= !out_wr_ptr_ff;
         end
         if (out_pop) begin
            out_rd_ptr_ff <= !out_rd_ptr_ff;
         end
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_mem_ff[out_wr_ptr_ff] <= rsp_new;
      end
   end

   assign rsp_item         = out_mem_ff[out_rd_ptr_ff];
   assign stat.phase       = phase_ff;
   assign stat.job_active  = active_ff;

endmodule

// ----- hdl/dictionary_rle_byte_decompressor_core.sv -----
// Top level of the dictionary and run-length byte decompressor.
// Path: a stream token is registered in the front end with its pair-table read, then passes
// through the two-entry queue and the decoder's result queue before it reaches the ports.
// Throughput: one item per cycle at the input while req_full is low; the decoder waits while its
// result queue is full and takes a table token as one run-length step per pair byte.
// Reset is synchronous and clears all control state; the pair table keeps unknown contents.
`include "assert_macros.svh"

module dictionary_rle_byte_decompressor_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  drbd_pkg::req_item_type req_item,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output drbd_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [17:0]            csr_data
);

   logic                     mid_push;
   logic                     mid_pop;
   drbd_pkg::mid_item_type   mid_in;
   drbd_pkg::mid_item_type   mid_head;
   drbd_pkg::queue_stat_type mid_stat;
   drbd_pkg::back_stat_type  back_stat;
   logic [5:0]               dest_bank_ff;
   logic [17:0]              length_ff;
   logic                     mid_full;
   logic                     mid_busy;
   logic                     job_idle;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_bank_ff <= 6'd0;
         length_ff    <= 18'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            drbd_pkg::CSR_DEST_BANK: begin
               dest_bank_ff <= csr_data[5:0];
            end
            drbd_pkg::CSR_LENGTH: begin
               length_ff <= csr_data;
            end
            default: begin
               length_ff <= length_ff;
            end
         endcase
      end
   end

   drbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .mid_stat (mid_stat),
      .mid_push (mid_push),
      .mid_item (mid_in)
   );

   drbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_item (mid_in),
      .pop       (mid_pop),
      .head_item (mid_head),
      .stat      (mid_stat)
   );

   drbd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (mid_head),
      .mid_stat     (mid_stat),
      .mid_pop      (mid_pop),
      .dest_bank    (dest_bank_ff),
      .length_field (length_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_item     (rsp_item),
      .stat         (back_stat)
   );

   assign mid_full = (mid_stat.count == drbd_pkg::QUEUE_DEPTH);
   assign mid_busy = (mid_stat.count != 2'd0);
   assign job_idle = !back_stat.job_active;

   `DRBD_ASSERT(a_full_only_when_queue_full, req_full |-> mid_full, "Full with queue room.")
   `DRBD_ASSERT(a_second_half_has_token, back_stat.phase |-> mid_busy, "Half token not queued.")
   `DRBD_ASSERT(a_idle_no_half_token, job_idle |-> !back_stat.phase, "Half token without job.")

endmodule
